// ----- rtl/pwli_pkg.sv -----
`timescale 1ns / 1ps

package pwli_pkg;

	localparam int TABLE_DEPTH_DEF = 64;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic               kind;
		logic [5:0]         entry_index;
		logic [15:0]        entry_wavelength;
		logic signed [31:0] entry_value;
		logic [15:0]        query_wavelength;
	} item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic               in_range;
	} result_t;

endpackage

// ----- rtl/piecewise_linear_table_interp.sv -----
`timescale 1ns / 1ps

// Piecewise-linear interpolation over a table of (wavelength, value) breakpoints
// kept in one synchronous memory with a write port and a read port. A load item
// writes one entry in the cycle it is accepted and gives no result. A query ends
// after reading the first and last entries when the table holds fewer than two
// entries or the query lies outside the first..last wavelengths; otherwise it
// runs the binary search (about log2 of entry_count steps, 6 for a full table of
// 64), one memory read per step, reads the two bracketing entries, and, when the
// fraction needs it, runs the radix-2 divider forming the Q0.16 fraction; one
// multiply, a shift truncating toward zero and an add follow. The result is
// shown for exactly one cycle with done high and must be taken then; busy stays
// high from the accepted query until its result, and entry_count must only be
// written while busy is low.
module piecewise_linear_table_interp #(
	parameter int TABLE_DEPTH = pwli_pkg::TABLE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [6:0]       cfg_wdata,
	input  logic             start,
	output logic             busy,
	input  pwli_pkg::item_t  item,
	output logic             done,
	output pwli_pkg::result_t result
);
	import pwli_pkg::*;

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	localparam logic [3:0] ST_IDLE   = 4'd0;
	localparam logic [3:0] ST_FIRST  = 4'd1;
	localparam logic [3:0] ST_LAST   = 4'd2;
	localparam logic [3:0] ST_CHK    = 4'd3;
	localparam logic [3:0] ST_SEARCH = 4'd4;
	localparam logic [3:0] ST_RD_O   = 4'd5;
	localparam logic [3:0] ST_O1     = 4'd6;
	localparam logic [3:0] ST_O2     = 4'd7;
	localparam logic [3:0] ST_DIV    = 4'd8;
	localparam logic [3:0] ST_MUL    = 4'd9;
	localparam logic [3:0] ST_FIN    = 4'd10;

	logic [3:0]          state_q;
	logic [6:0]          entry_count_q;
	logic [CW-1:0]       n_q;
	logic [15:0]         q_q;
	logic [15:0]         w0_q;
	logic signed [31:0]  v0_q;
	logic [CW-1:0]       first_q;
	logic [CW-1:0]       size_q;
	logic [CW-1:0]       mid_q;
	logic [AW-1:0]       o_q;
	logic [15:0]         wo_q;
	logic signed [31:0]  vo_q;
	logic signed [32:0]  diff_q;
	logic [15:0]         den_q;
	logic [15:0]         rem_q;
	logic [16:0]         t_q;
	logic [3:0]          cnt_q;
	logic signed [50:0]  prod_q;
	logic                done_q;
	result_t             result_q;

	// memory: {wavelength, value}
	logic [47:0]         mem [TABLE_DEPTH];
	logic [47:0]         rdata_q;
	logic [AW-1:0]       rd_addr;
	logic                wr_en;
	logic [AW-1:0]       wr_addr;
	logic [31:0]         widx;

	logic [15:0]         rd_w;
	logic signed [31:0]  rd_v;
	logic [CW-1:0]       n_now;
	logic [CW-1:0]       nm1;
	logic [CW-1:0]       size0;
	logic [CW-1:0]       mid0;
	logic [CW-1:0]       half;
	logic [CW-1:0]       first_n;
	logic [CW-1:0]       size_n;
	logic [CW-1:0]       mid_n;
	logic [CW-1:0]       o_n;
	logic signed [16:0]  num;
	logic signed [16:0]  den;
	logic [16:0]         rem2;
	logic                qbit;
	logic signed [50:0]  prod_adj;
	logic signed [50:0]  prod_sh;

	assign rd_w = rdata_q[47:32];
	assign rd_v = rdata_q[31:0];

	always_comb begin
		if (32'(entry_count_q) > TABLE_DEPTH)
			n_now = CW'(TABLE_DEPTH);
		else
			n_now = CW'(entry_count_q);
	end

	assign nm1   = n_q - CW'(1);
	assign size0 = n_q - CW'(2);
	assign mid0  = CW'(1) + (size0 >> 1);

	// one binary-search step against the entry read at mid_q
	always_comb begin
		half = size_q >> 1;
		if (rd_w <= q_q) begin
			first_n = mid_q + CW'(1);
			size_n  = size_q - half - CW'(1);
		end else begin
			first_n = first_q;
			size_n  = half;
		end
		mid_n = first_n + (size_n >> 1);
		if (first_n - CW'(1) > size0)
			o_n = size0;
		else
			o_n = first_n - CW'(1);
	end

	always_comb begin
		rd_addr = '0;
		case (state_q)
			ST_FIRST:  rd_addr = '0;
			ST_LAST:   rd_addr = nm1[AW-1:0];
			ST_CHK:    rd_addr = mid0[AW-1:0];
			ST_SEARCH: rd_addr = mid_n[AW-1:0];
			ST_RD_O:   rd_addr = o_q;
			ST_O1:     rd_addr = o_q + AW'(1);
			default:   rd_addr = '0;
		endcase
	end

	assign widx    = 32'(item.entry_index);
	assign wr_addr = widx[AW-1:0];
	assign wr_en   = start && !busy && (item.kind == KIND_LOAD) && (widx < TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {item.entry_wavelength, item.entry_value};
		rdata_q <= mem[rd_addr];
	end

	assign num = $signed({1'b0, q_q}) - $signed({1'b0, wo_q});
	assign den = $signed({1'b0, rd_w}) - $signed({1'b0, wo_q});

	assign rem2 = {rem_q, 1'b0};
	assign qbit = rem2 >= {1'b0, den_q};

	// truncate toward zero on the divide by 2^16
	assign prod_adj = (prod_q < 0) ? prod_q + 51'sd65535 : prod_q;
	assign prod_sh  = prod_adj >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_count_q <= '0;
		end else if (cfg_we) begin
			entry_count_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start && item.kind == KIND_QUERY)
						state_q <= ST_FIRST;
				end
				ST_FIRST:  state_q <= ST_LAST;
				ST_LAST:   state_q <= ST_CHK;
				ST_CHK: begin
					if (n_q >= CW'(2) && q_q >= w0_q && q_q <= rd_w) begin
						if (size0 == '0)
							state_q <= ST_RD_O;
						else
							state_q <= ST_SEARCH;
					end else begin
						done_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				ST_SEARCH: begin
					if (size_n == '0)
						state_q <= ST_RD_O;
				end
				ST_RD_O:   state_q <= ST_O1;
				ST_O1:     state_q <= ST_O2;
				ST_O2: begin
					if (num < 0 || den <= 0 || num >= den)
						state_q <= ST_MUL;
					else
						state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (cnt_q == 4'd15)
						state_q <= ST_MUL;
				end
				ST_MUL:    state_q <= ST_FIN;
				ST_FIN: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				n_q <= n_now;
				q_q <= item.query_wavelength;
			end
			ST_LAST: begin
				w0_q <= rd_w;
				v0_q <= rd_v;
			end
			ST_CHK: begin
				first_q <= CW'(1);
				size_q  <= size0;
				mid_q   <= mid0;
				o_q     <= '0;
				if (n_q == CW'(1) && q_q == w0_q) begin
					result_q.value    <= v0_q;
					result_q.in_range <= 1'b1;
				end else begin
					result_q.value    <= '0;
					result_q.in_range <= 1'b0;
				end
			end
			ST_SEARCH: begin
				first_q <= first_n;
				size_q  <= size_n;
				mid_q   <= mid_n;
				o_q     <= o_n[AW-1:0];
			end
			ST_O1: begin
				wo_q <= rd_w;
				vo_q <= rd_v;
			end
			ST_O2: begin
				diff_q <= 33'(rd_v) - 33'(vo_q);
				den_q  <= den[15:0];
				rem_q  <= num[15:0];
				cnt_q  <= '0;
				if (num < 0 || den <= 0)
					t_q <= '0;
				else if (num >= den)
					t_q <= 17'h10000;
				else
					t_q <= '0;
			end
			ST_DIV: begin
				// restoring division, one quotient bit per cycle
				if (qbit)
					rem_q <= 16'(rem2 - {1'b0, den_q});
				else
					rem_q <= rem2[15:0];
				t_q   <= {t_q[15:0], qbit};
				cnt_q <= cnt_q + 4'd1;
			end
			ST_MUL: begin
				prod_q <= 51'(diff_q * $signed({1'b0, t_q}));
			end
			ST_FIN: begin
				result_q.value    <= vo_q + prod_sh[31:0];
				result_q.in_range <= 1'b1;
			end
			default: ;
		endcase
	end

	assign busy   = state_q != ST_IDLE;
	assign done   = done_q;
	assign result = result_q;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
	import pwli_pkg::*;

	class interp_scoreboard;
		logic [15:0]        wl_tab[64];
		logic signed [31:0] val_tab[64];
		logic [6:0]         count;
		result_t            pending_interp[$];
		int                 errors;
		int                 queries;
		int                 hits;
		int                 loads;

		function new();
			count = '0;
			errors = 0;
			queries = 0;
			hits = 0;
			loads = 0;
			foreach (wl_tab[i]) begin
				wl_tab[i] = '0;
				val_tab[i] = '0;
			end
		endfunction

		function result_t interpolate(logic [15:0] q);
			result_t r;
			int n, first, size, half, mid, o, qi, wlo, whi, num, den;
			longint t, a, b, v;
			r = '0;
			n = (count > 64) ? 64 : count;
			qi = q;
			if (n == 1) begin
				if (q == wl_tab[0]) begin
					r.value = val_tab[0];
					r.in_range = 1'b1;
				end
			end else if (n >= 2 && q >= wl_tab[0] && q <= wl_tab[n - 1]) begin
				// largest breakpoint at or below q, limited to n-2
				first = 1;
				size = n - 2;
				while (size > 0) begin
					half = size >> 1;
					mid = first + half;
					if (wl_tab[mid] <= q) begin
						first = mid + 1;
						size -= half + 1;
					end else begin
						size = half;
					end
				end
				o = (first - 1 > n - 2) ? n - 2 : first - 1;
				wlo = wl_tab[o];
				whi = wl_tab[o + 1];
				num = qi - wlo;
				den = whi - wlo;
				a = val_tab[o];
				b = val_tab[o + 1];
				if (num < 0 || den <= 0)
					t = 0;
				else if (num >= den)
					t = 65536;
				else
					t = (longint'(num) * 65536) / den;
				v = a + ((b - a) * t) / 65536;
				r.value = v[31:0];
				r.in_range = 1'b1;
			end
			return r;
		endfunction

		function void note_item(item_t it);
			if (it.kind == KIND_LOAD) begin
				wl_tab[it.entry_index] = it.entry_wavelength;
				val_tab[it.entry_index] = it.entry_value;
				loads++;
			end else begin
				pending_interp = {pending_interp, interpolate(it.query_wavelength)};
				queries++;
			end
		endfunction

		function void check_result(result_t r);
			result_t e;
			if (pending_interp.size() == 0) begin
				$error("result with no query outstanding: value %0d in_range %0b",
					r.value, r.in_range);
				errors++;
				return;
			end
			e = pending_interp.pop_front();
			if (e.in_range) hits++;
			if (r.value !== e.value) begin
				$error("value: expected %0d, actual %0d", e.value, r.value);
				errors++;
			end
			if (r.in_range !== e.in_range) begin
				$error("in_range: expected %0b, actual %0b", e.in_range, r.in_range);
				errors++;
			end
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we = 1'b0;
	logic [6:0] cfg_wdata = '0;
	logic       start = 1'b0;
	item_t      item = '0;
	logic       busy;
	logic       done;
	result_t    result;

	interp_scoreboard sb;
	int sent = 0;
	int count_writes = 0;

	localparam int TOTAL_ITEMS = 1130;

	piecewise_linear_table_interp dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.start    (start),
		.busy     (busy),
		.item     (item),
		.done     (done),
		.result   (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic send_item(input item_t it);
		int gap, pct;
		pct = (sent < 400) ? 15 : (sent < 790) ? 80 : 0;
		gap = 0;
		while ($urandom_range(0, 99) < pct && gap < 40)
			gap++;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_item(it);
		sent++;
	endtask

	task automatic load_entry(input int idx, input logic [15:0] w, input logic [31:0] v);
		item_t it;
		it.kind = KIND_LOAD;
		it.entry_index = idx[5:0];
		it.entry_wavelength = w;
		it.entry_value = v;
		it.query_wavelength = 16'($urandom);
		send_item(it);
	endtask

	task automatic query_at(input logic [15:0] q);
		item_t it;
		it.kind = KIND_QUERY;
		it.entry_index = 6'($urandom);
		it.entry_wavelength = 16'($urandom);
		it.entry_value = $urandom;
		it.query_wavelength = q;
		send_item(it);
	endtask

	// block must be idle: all results in, then room for a query still in flight
	task automatic set_count(input logic [6:0] c);
		int guard;
		start <= 1'b0;
		guard = 0;
		while (sb.pending_interp.size() != 0 && guard < 5000) begin
			@(posedge clk);
			guard++;
		end
		repeat (40) @(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= c;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.count = c;
		count_writes++;
	endtask

	task automatic load_table(input int k);
		int w, step_max, i;
		logic [31:0] v;
		bit noisy;
		noisy = ($urandom_range(0, 6) == 0);
		w = $urandom_range(0, 3000);
		step_max = (65535 - w) / k;
		for (i = 0; i < k; i++) begin
			if (i > 0)
				w += $urandom_range(1, step_max);
			if ($urandom_range(0, 3) == 0)
				v = $urandom_range(0, 2000) - 1000;
			else
				v = $urandom;
			if (noisy)
				load_entry(i, 16'($urandom), v);
			else
				load_entry(i, w[15:0], v);
		end
	endtask

	task automatic random_query(input int n);
		logic [15:0] lo, hi, q;
		int sel, pick;
		lo = sb.wl_tab[0];
		hi = (n >= 1) ? sb.wl_tab[n - 1] : 16'hffff;
		sel = $urandom_range(0, 19);
		if (sel < 10) begin
			q = 16'($urandom_range(lo, hi));
		end else if (sel < 13) begin
			pick = (n >= 1) ? $urandom_range(0, n - 1) : 0;
			q = sb.wl_tab[pick];
		end else if (sel < 16) begin
			q = ($urandom_range(0, 1) == 0) ? lo - 16'd1 : hi + 16'd1;
		end else begin
			q = 16'($urandom);
		end
		query_at(q);
	endtask

	initial begin
		int c, n, m, j, sel;
		bit first_phase;
		sb = new();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table after reset
		query_at(16'h0000);
		query_at(16'hffff);

		// single entry and a two-entry table spanning the whole range
		load_entry(0, 16'h0000, 32'h7fffffff);
		load_entry(1, 16'hffff, 32'h80000000);
		set_count(7'd1);
		query_at(16'h0000);
		query_at(16'h0001);
		set_count(7'd2);
		query_at(16'h0000);
		query_at(16'hffff);
		query_at(16'h8000);
		query_at(16'h0001);
		query_at(16'hfffe);

		// equal and falling wavelengths in the middle of the table
		load_entry(0, 16'h0100, 32'h00000000);
		load_entry(1, 16'h0200, 32'h00010000);
		load_entry(2, 16'h0200, 32'hffffffff);
		load_entry(3, 16'h0180, 32'h80000000);
		load_entry(4, 16'h0400, 32'h7fffffff);
		set_count(7'd5);
		query_at(16'h00ff);
		query_at(16'h0401);
		query_at(16'h0100);
		query_at(16'h0180);
		query_at(16'h0200);
		query_at(16'h0300);
		query_at(16'h0400);

		first_phase = 1'b1;
		while (sent < TOTAL_ITEMS) begin
			sel = $urandom_range(0, 19);
			case (sel)
				0: c = 0;
				1: c = 1;
				2: c = 64;
				3: c = $urandom_range(65, 127);
				4: c = 127;
				5, 6, 7, 8, 9, 10, 11, 12: c = $urandom_range(2, 12);
				default: c = $urandom_range(2, 64);
			endcase
			n = (c > 64) ? 64 : c;
			set_count(c[6:0]);
			// every entry gets written once before any count can reach it
			if (first_phase)
				load_table(64);
			else if (n > 0 && $urandom_range(0, 9) < 7)
				load_table(n);
			first_phase = 1'b0;
			m = $urandom_range(8, 40);
			for (j = 0; j < m; j++) begin
				if ($urandom_range(0, 9) == 0)
					load_entry($urandom_range(0, 63), 16'($urandom), $urandom);
				else
					random_query(n);
			end
		end
		start <= 1'b0;

		j = 0;
		while (sb.pending_interp.size() != 0 && j < 5000) begin
			@(posedge clk);
			j++;
		end
		repeat (40) @(posedge clk);

		$display("covered %0d queries (%0d in range) and %0d table loads", sb.queries,
			sb.hits, sb.loads);
		$display("over %0d entry_count settings from empty through over-full", count_writes);
		if (sb.errors == 0 && sb.pending_interp.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule
